[rtl/radial_vignetting_correction_assert.svh]
// ------------------------------------------------------------------------
// Vignetting correction assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ------------------------------------------------------------------------
`ifndef RADIAL_VIGNETTING_CORRECTION_ASSERT_SVH
`define RADIAL_VIGNETTING_CORRECTION_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rvc_pkg.sv]
// ------------------------------------------------------------------------
// rvc_pkg
// Shared types, widths and register indexes of the vignetting correction.
// ------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

  // coordinate width default
  localparam int COORD_BITS_DEF = 12;

  // config port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_DIAG_SQ = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_C      = 3'd5;

  // datapath widths
  localparam int SAMPLE_BITS = 8;
  localparam int CENTER_BITS = 16;
  localparam int INV_BITS    = 32;
  localparam int COEF_BITS   = 21;
  localparam int R2_BITS     = 18;                      // Q2.16
  localparam int R4_BITS     = 20;
  localparam int R6_BITS     = 22;
  localparam int TA_BITS     = COEF_BITS + R2_BITS + 1;
  localparam int TB_BITS     = COEF_BITS + R4_BITS + 1;
  localparam int TC_BITS     = COEF_BITS + R6_BITS + 1;
  localparam int SAB_BITS    = TB_BITS + 1;
  localparam int GAIN_BITS   = 46;                      // signed Q.32
  localparam int FRAC_BITS   = 32;
  localparam int PROD_BITS   = GAIN_BITS + SAMPLE_BITS + 1;
  localparam int INT_BITS    = PROD_BITS - FRAC_BITS;

  localparam logic [R2_BITS-1:0] R2_MAX = '1;
  localparam logic signed [GAIN_BITS-1:0] ONE_Q32 = GAIN_BITS'(64'h1_0000_0000);

  // pipeline depth per unit
  localparam int RAD_STAGES   = 5;
  localparam int GAIN_STAGES  = 4;
  localparam int APPLY_STAGES = 3;
  localparam int PIPE_STAGES  = RAD_STAGES + GAIN_STAGES + APPLY_STAGES;

  typedef struct packed {
    logic [CENTER_BITS-1:0]        center_x;
    logic [CENTER_BITS-1:0]        center_y;
    logic [INV_BITS-1:0]           inv_diag_sq;
    logic signed [COEF_BITS-1:0]   coef_a;
    logic signed [COEF_BITS-1:0]   coef_b;
    logic signed [COEF_BITS-1:0]   coef_c;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    center_x:    16'h8000,
    center_y:    16'h8000,
    inv_diag_sq: 32'h0,
    coef_a:      21'sh0,
    coef_b:      21'sh0,
    coef_c:      21'sh0
  };

endpackage

`default_nettype wire

[rtl/radial_vignetting_correction.sv]
// ------------------------------------------------------------------------
// radial_vignetting_correction: radial polynomial gain on a pixel stream
// An accepted item moves through the radius, gain and apply stages in order
// to m_tdata and m_tvalid.
// One item per cycle sustained while m_tready stays high, set by a 12-stage
// pipeline with at most one multiply layer per stage.
// Reset clears all valid bits and loads the register reset values.
// ------------------------------------------------------------------------
`default_nettype none

`include "radial_vignetting_correction_assert.svh"

module radial_vignetting_correction #(
  parameter int COORD_BITS = rvc_pkg::COORD_BITS_DEF,
  localparam int IN_BITS = ((rvc_pkg::SAMPLE_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [IN_BITS-1:0]                  s_tdata,  // sample, column, row
  // output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata,  // corrected
  output logic [0:0]                               m_tuser,  // clamped
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rvc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rvc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int RS = rvc_pkg::RAD_STAGES;
  localparam int GS = rvc_pkg::GAIN_STAGES;
  localparam int PS = rvc_pkg::PIPE_STAGES;

  rvc_pkg::cfg_regs_t                      cfg;
  logic [PS-1:0]                           en;
  logic [PS-1:0]                           pipe_valid;
  logic [rvc_pkg::R2_BITS-1:0]             r2;
  logic [rvc_pkg::SAMPLE_BITS-1:0]         smp_rad, smp_gain;
  logic signed [rvc_pkg::GAIN_BITS-1:0]    gain;
  logic [rvc_pkg::SAMPLE_BITS-1:0]         corrected;
  logic                                    clamped;

  // register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= rvc_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rvc_pkg::CFG_CENTER_X:    cfg.center_x    <= cfg_data[rvc_pkg::CENTER_BITS-1:0];
        rvc_pkg::CFG_CENTER_Y:    cfg.center_y    <= cfg_data[rvc_pkg::CENTER_BITS-1:0];
        rvc_pkg::CFG_INV_DIAG_SQ: cfg.inv_diag_sq <= cfg_data[rvc_pkg::INV_BITS-1:0];
        rvc_pkg::CFG_COEF_A:      cfg.coef_a <= $signed(cfg_data[rvc_pkg::COEF_BITS-1:0]);
        rvc_pkg::CFG_COEF_B:      cfg.coef_b <= $signed(cfg_data[rvc_pkg::COEF_BITS-1:0]);
        rvc_pkg::CFG_COEF_C:      cfg.coef_c <= $signed(cfg_data[rvc_pkg::COEF_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

  // stage control
  rvc_pipe_ctrl #(
    .STAGES (PS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .out_ready   (m_tready),
    .en          (en),
    .stage_valid (pipe_valid)
  );

  // radius
  rvc_radius #(
    .COORD_BITS (COORD_BITS)
  ) u_radius (
    .clk        (clk),
    .en         (en[RS-1:0]),
    .cfg        (cfg),
    .sample     (s_tdata[rvc_pkg::SAMPLE_BITS-1:0]),
    .column     (s_tdata[rvc_pkg::SAMPLE_BITS +: COORD_BITS]),
    .row        (s_tdata[rvc_pkg::SAMPLE_BITS + COORD_BITS +: COORD_BITS]),
    .r2         (r2),
    .sample_out (smp_rad)
  );

  // gain polynomial
  rvc_gain u_gain (
    .clk        (clk),
    .en         (en[RS+GS-1:RS]),
    .cfg        (cfg),
    .r2         (r2),
    .sample     (smp_rad),
    .gain       (gain),
    .sample_out (smp_gain)
  );

  // apply, round, saturate
  rvc_apply u_apply (
    .clk       (clk),
    .en        (en[PS-1:RS+GS]),
    .sample    (smp_gain),
    .gain      (gain),
    .corrected (corrected),
    .clamped   (clamped)
  );

  assign m_tvalid   = pipe_valid[PS-1];
  assign m_tdata    = corrected;
  assign m_tuser[0] = clamped;

  // checks
  `RVC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, pipe_valid[0], "accepted item not in stage 0")
  `RVC_ASSERT_NOW(a_full_stall, m_tvalid && !m_tready && (&pipe_valid), !s_tready, "full pipe took an item")
  `RVC_ASSERT_NOW(a_clamp_value, m_tvalid && m_tuser[0], m_tdata == 8'd0 || m_tdata == 8'd255, "clamp flag on an unsaturated value")
  `RVC_ASSERT_NEXT(a_coef_write, cfg_valid && cfg_ready && cfg_index == rvc_pkg::CFG_COEF_A, cfg.coef_a == $signed($past(cfg_data[rvc_pkg::COEF_BITS-1:0])), "coef_a write lost")

endmodule

`default_nettype wire

[rtl/rvc_pipe_ctrl.sv]
// ------------------------------------------------------------------------
// rvc_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty
// or when the stage after it moves, so bubbles close up under a stall.
// ------------------------------------------------------------------------
`default_nettype none

module rvc_pipe_ctrl #(
  parameter int STAGES = rvc_pkg::PIPE_STAGES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic [STAGES-1:0]      en,
  output logic [STAGES-1:0]      stage_valid
);

  logic [STAGES-1:0] valid_in;

  // ready chain from the output back to the input
  assign en[STAGES-1] = !stage_valid[STAGES-1] || out_ready;

  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = !stage_valid[k] || en[k+1];
  end

  assign valid_in = {stage_valid[STAGES-2:0], in_valid};
  assign in_ready = en[0];

  // valid bits follow their item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= valid_in[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rvc_radius.sv]
// ------------------------------------------------------------------------
// rvc_radius
// Normalized squared radius: offset, square, sum, scale by the
// reciprocal squared diagonal in two 16-bit halves, clamp below 4.0.
// ------------------------------------------------------------------------
`default_nettype none

module rvc_radius #(
  parameter int COORD_BITS = rvc_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic [rvc_pkg::RAD_STAGES-1:0]     en,
  input  wire rvc_pkg::cfg_regs_t                 cfg,
  input  wire logic [rvc_pkg::SAMPLE_BITS-1:0]    sample,
  input  wire logic [COORD_BITS-1:0]              column,
  input  wire logic [COORD_BITS-1:0]              row,
  output logic [rvc_pkg::R2_BITS-1:0]             r2,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]         sample_out
);

  localparam int CXW = COORD_BITS + 4;
  localparam int PW  = (CXW > rvc_pkg::CENTER_BITS) ? CXW : rvc_pkg::CENTER_BITS;
  localparam int DW  = PW + 1;
  localparam int SQW = 2 * DW - 1;
  localparam int DSW = 2 * DW;
  localparam int LOW = DSW + 16;

  logic [rvc_pkg::SAMPLE_BITS-1:0] smp [rvc_pkg::RAD_STAGES];

  logic signed [DW-1:0]    dx, dy;
  logic signed [2*DW-1:0]  px, py;
  logic [SQW-1:0]          sqx, sqy;
  logic [DSW-1:0]          dist_sq;
  logic [LOW-1:0]          lo_prod, hi_prod, lo, hi;
  logic [LOW:0]            acc;
  logic [DSW:0]            r2_full;

  // sample rides along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      smp[0] <= sample;
    end
    for (int k = 1; k < rvc_pkg::RAD_STAGES; k++) begin
      if (en[k]) begin
        smp[k] <= smp[k-1];
      end
    end
  end

  // stage 1: offsets from the center in Q.4
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx <= $signed({{(DW-CXW){1'b0}}, column, 4'b0000})
          - $signed({{(DW-rvc_pkg::CENTER_BITS){1'b0}}, cfg.center_x});
      dy <= $signed({{(DW-CXW){1'b0}}, row, 4'b0000})
          - $signed({{(DW-rvc_pkg::CENTER_BITS){1'b0}}, cfg.center_y});
    end
  end

  // stage 2: squares
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx <= px[SQW-1:0];
      sqy <= py[SQW-1:0];
    end
  end

  // stage 3: squared distance, Q.8
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dist_sq <= {1'b0, sqx} + {1'b0, sqy};
    end
  end

  // stage 4: scale, low and high halves of the reciprocal
  assign lo_prod = dist_sq * cfg.inv_diag_sq[15:0];
  assign hi_prod = dist_sq * cfg.inv_diag_sq[31:16];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lo <= lo_prod;
      hi <= hi_prod;
    end
  end

  // stage 5: merge halves, drop 32 fraction bits, clamp
  assign acc     = {1'b0, hi} + {17'b0, lo[LOW-1:16]};
  assign r2_full = acc[LOW:16];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (|r2_full[DSW:rvc_pkg::R2_BITS]) begin
        r2 <= rvc_pkg::R2_MAX;
      end else begin
        r2 <= r2_full[rvc_pkg::R2_BITS-1:0];
      end
    end
  end

  assign sample_out = smp[rvc_pkg::RAD_STAGES-1];

endmodule

`default_nettype wire

[rtl/rvc_gain.sv]
// ------------------------------------------------------------------------
// rvc_gain
// Polynomial gain 1 + a*r2 + b*r4 + c*r6 in signed Q.32, at most one multiply
// per operand per stage.
// ------------------------------------------------------------------------
`default_nettype none

module rvc_gain (
  input  wire logic                                clk,
  input  wire logic [rvc_pkg::GAIN_STAGES-1:0]     en,
  input  wire rvc_pkg::cfg_regs_t                  cfg,
  input  wire logic [rvc_pkg::R2_BITS-1:0]         r2,
  input  wire logic [rvc_pkg::SAMPLE_BITS-1:0]     sample,
  output logic signed [rvc_pkg::GAIN_BITS-1:0]     gain,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]          sample_out
);

  logic [rvc_pkg::SAMPLE_BITS-1:0] smp [rvc_pkg::GAIN_STAGES];

  logic [2*rvc_pkg::R2_BITS-1:0]                   sq2;
  logic [rvc_pkg::R4_BITS+rvc_pkg::R2_BITS-1:0]    sq6;
  logic [rvc_pkg::R2_BITS-1:0]                     r2_d;
  logic [rvc_pkg::R4_BITS-1:0]                     r4;
  logic [rvc_pkg::R6_BITS-1:0]                     r6;
  logic signed [rvc_pkg::TA_BITS-1:0]              ta_prod, ta, ta_d;
  logic signed [rvc_pkg::TB_BITS-1:0]              tb_prod, tb;
  logic signed [rvc_pkg::TC_BITS-1:0]              tc_prod, tc;
  logic signed [rvc_pkg::SAB_BITS-1:0]             sab;

  // sample rides along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      smp[0] <= sample;
    end
    for (int k = 1; k < rvc_pkg::GAIN_STAGES; k++) begin
      if (en[k]) begin
        smp[k] <= smp[k-1];
      end
    end
  end

  // stage 1: r4 and the second-order term
  assign sq2     = r2 * r2;
  assign ta_prod = $signed(cfg.coef_a) * $signed({1'b0, r2});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r2_d <= r2;
      r4   <= sq2[2*rvc_pkg::R2_BITS-1:16];
      ta   <= ta_prod;
    end
  end

  // stage 2: r6 and the fourth-order term
  assign sq6     = r4 * r2_d;
  assign tb_prod = $signed(cfg.coef_b) * $signed({1'b0, r4});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r6   <= sq6[rvc_pkg::R4_BITS+rvc_pkg::R2_BITS-1:16];
      tb   <= tb_prod;
      ta_d <= ta;
    end
  end

  // stage 3: sixth-order term, partial sum
  assign tc_prod = $signed(cfg.coef_c) * $signed({1'b0, r6});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tc  <= tc_prod;
      sab <= $signed({{(rvc_pkg::SAB_BITS-rvc_pkg::TA_BITS){ta_d[rvc_pkg::TA_BITS-1]}}, ta_d})
           + $signed({{(rvc_pkg::SAB_BITS-rvc_pkg::TB_BITS){tb[rvc_pkg::TB_BITS-1]}}, tb});
    end
  end

  // stage 4: final gain
  always_ff @(posedge clk) begin
    if (en[3]) begin
      gain <= rvc_pkg::ONE_Q32
            + $signed({{(rvc_pkg::GAIN_BITS-rvc_pkg::SAB_BITS){sab[rvc_pkg::SAB_BITS-1]}}, sab})
            + $signed({{(rvc_pkg::GAIN_BITS-rvc_pkg::TC_BITS){tc[rvc_pkg::TC_BITS-1]}}, tc});
    end
  end

  assign sample_out = smp[rvc_pkg::GAIN_STAGES-1];

endmodule

`default_nettype wire

[rtl/rvc_apply.sv]
// ------------------------------------------------------------------------
// rvc_apply
// Sample times gain, round to nearest with ties to even, saturate to
// 0..255 and flag a clamp.
// ------------------------------------------------------------------------
`default_nettype none

module rvc_apply (
  input  wire logic                                clk,
  input  wire logic [rvc_pkg::APPLY_STAGES-1:0]    en,
  input  wire logic [rvc_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic signed [rvc_pkg::GAIN_BITS-1:0] gain,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]          corrected,
  output logic                                     clamped
);

  localparam int PB = rvc_pkg::PROD_BITS;
  localparam int FB = rvc_pkg::FRAC_BITS;
  localparam int IB = rvc_pkg::INT_BITS;

  logic signed [PB-1:0] prod_c, prod;
  logic [PB-1:0]        mag;
  logic                 neg;
  logic [IB-1:0]        q;
  logic                 rup;
  logic [IB:0]          rq;

  // stage 1: product in Q.32
  assign prod_c = $signed({1'b0, sample}) * gain;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= prod_c;
    end
  end

  // stage 2: magnitude, integer part and round-up decision
  assign mag = prod[PB-1] ? $unsigned(-prod) : $unsigned(prod);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg <= prod[PB-1];
      q   <= mag[PB-1:FB];
      rup <= mag[FB-1] && ((|mag[FB-2:0]) || mag[FB]);
    end
  end

  // stage 3: increment and saturate
  assign rq = {1'b0, q} + {{IB{1'b0}}, rup};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (neg) begin
        corrected <= '0;
        clamped   <= |rq;
      end else if (|rq[IB:rvc_pkg::SAMPLE_BITS]) begin
        corrected <= '1;
        clamped   <= 1'b1;
      end else begin
        corrected <= rq[rvc_pkg::SAMPLE_BITS-1:0];
        clamped   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
